// ===== sv/dqne_pkg.sv =====
`default_nettype none
package dqne_pkg;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [15:0] query_id;
        logic [15:0] header_flags;
        logic [15:0] query_type;
        logic [15:0] query_class;
    } t_cfg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CLASS  = 3'd3;

    localparam logic [15:0] RST_QUERY_ID     = 16'hAAAA;
    localparam logic [15:0] RST_HEADER_FLAGS = 16'h0100;
    localparam logic [15:0] RST_QUERY_TYPE   = 16'h0001;
    localparam logic [15:0] RST_QUERY_CLASS  = 16'h0001;

    localparam t_byte DOT_CHAR = 8'h2E;

    localparam logic [3:0] HDR_LAST  = 4'd11;
    localparam logic [3:0] TAIL_LAST = 4'd4;

    // header: id, flags, qdcount = 1, an/ns/ar counts = 0
    function automatic t_byte hdr_byte(input logic [3:0] idx, input t_cfg cfg);
        case (idx)
            4'd0:    hdr_byte = cfg.query_id[15:8];
            4'd1:    hdr_byte = cfg.query_id[7:0];
            4'd2:    hdr_byte = cfg.header_flags[15:8];
            4'd3:    hdr_byte = cfg.header_flags[7:0];
            4'd5:    hdr_byte = 8'd1;
            default: hdr_byte = 8'd0;
        endcase
    endfunction

    // tail: root zero byte, type, class
    function automatic t_byte tail_byte(input logic [3:0] idx, input t_cfg cfg);
        case (idx)
            4'd1:    tail_byte = cfg.query_type[15:8];
            4'd2:    tail_byte = cfg.query_type[7:0];
            4'd3:    tail_byte = cfg.query_class[15:8];
            4'd4:    tail_byte = cfg.query_class[7:0];
            default: tail_byte = 8'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== sv/dqne_lbuf.sv =====
`default_nettype none
module dqne_lbuf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire dqne_pkg::t_byte   i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output dqne_pkg::t_byte        o_rdata
);
    import dqne_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/dqne_seq.sv =====
`default_nettype none
module dqne_seq #(
    parameter int LABEL_MAX = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dqne_pkg::t_cfg    i_cfg,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic              i_action,
    input  wire dqne_pkg::t_byte   i_char,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output dqne_pkg::t_byte        o_m_byte,
    output logic                   o_m_last,
    output logic                   o_m_ovf
);
    import dqne_pkg::*;

    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam int CW = $clog2(LABEL_MAX + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(LABEL_MAX);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_LRD  = 3'd4;
    localparam logic [2:0] S_LPUT = 3'd5;
    localparam logic [2:0] S_TAIL = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [3:0]    r_idx, n_idx;
    logic          r_act, n_act;
    t_byte         r_ch, n_ch;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_len, n_len;
    logic [AW-1:0] r_k, n_k;
    logic          r_in_name, n_in_name;
    logic          r_drop, n_drop;

    logic          r_ovalid;
    t_byte         r_odata;
    logic          r_olast;
    logic          r_ouser;

    logic          slot_free;
    logic          emit;
    t_byte         e_byte;
    logic          e_last;
    logic          e_ovf;
    logic          we;
    logic          re;
    t_byte         rdata;

    dqne_lbuf #(
        .DEPTH (LABEL_MAX),
        .AW    (AW)
    ) u_lbuf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_ch),
        .i_re    (re),
        .i_raddr (r_k),
        .o_rdata (rdata)
    );

    assign slot_free = !r_ovalid || i_m_tready;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_act     = r_act;
        n_ch      = r_ch;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_k       = r_k;
        n_in_name = r_in_name;
        n_drop    = r_drop;
        emit      = 1'b0;
        e_byte    = '0;
        e_last    = 1'b0;
        e_ovf     = 1'b0;
        we        = 1'b0;
        re        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_act   = i_action;
                    n_ch    = i_char;
                    n_idx   = '0;
                    n_state = r_in_name ? S_DISP : S_HDR;
                end
            end
            S_HDR: begin
                e_byte = hdr_byte(r_idx, i_cfg);
                if (slot_free) begin
                    emit = 1'b1;
                    if (r_idx == HDR_LAST) begin
                        n_in_name = 1'b1;
                        n_state   = S_DISP;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_DISP: begin
                if (r_act || r_ch == DOT_CHAR) begin
                    n_state = S_LEN;
                end else begin
                    if (r_cnt < CNT_MAX) begin
                        we    = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LEN: begin
                e_byte = 8'(r_cnt);
                e_ovf  = r_drop;
                if (slot_free) begin
                    emit   = 1'b1;
                    n_len  = r_cnt;
                    n_cnt  = '0;
                    n_drop = 1'b0;
                    n_k    = '0;
                    n_idx  = '0;
                    if (r_cnt == '0) begin
                        n_state = r_act ? S_TAIL : S_IDLE;
                    end else begin
                        n_state = S_LRD;
                    end
                end
            end
            S_LRD: begin
                re      = 1'b1;
                n_state = S_LPUT;
            end
            S_LPUT: begin
                e_byte = rdata;
                if (slot_free) begin
                    emit = 1'b1;
                    if (CW'(r_k) + CW'(1) == r_len) begin
                        n_state = r_act ? S_TAIL : S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_LRD;
                    end
                end
            end
            S_TAIL: begin
                e_byte = tail_byte(r_idx, i_cfg);
                e_last = (r_idx == TAIL_LAST);
                if (slot_free) begin
                    emit = 1'b1;
                    if (r_idx == TAIL_LAST) begin
                        n_in_name = 1'b0;
                        n_state   = S_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_in_name <= 1'b0;
            r_drop    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_in_name <= n_in_name;
            r_drop    <= n_drop;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_act <= n_act;
        r_ch  <= n_ch;
        r_len <= n_len;
        r_k   <= n_k;
        if (emit) begin
            r_odata <= e_byte;
            r_olast <= e_last;
            r_ouser <= e_ovf;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_byte   = r_odata;
    assign o_m_last   = r_olast;
    assign o_m_ovf    = r_ouser;

endmodule
`default_nettype wire

// ===== sv/dns_query_name_encoder_unit.sv =====
`default_nettype none
// DNS query builder (A-record type by reset default). Host name characters enter
// one word at a time on the slave stream (tuser = 1 marks end of name); the query
// packet leaves one byte per word on the master stream, tlast on its final byte.
// A plain character is accepted, then stored into the label memory. The first
// word of a name sends the header first. A dot or end of name sends the length
// byte, then each buffered character, read through the label memory's
// registered read port ahead of the output register; end of name then sends the
// root byte, type and class. Output stalls hold the sequence. Characters past
// LABEL_MAX in one label are dropped and the length byte carries tuser = 1.
// Config writes are always taken and must only happen while the block is idle.
module dns_query_name_encoder_unit #(
    parameter int LABEL_MAX = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dqne_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] name_char
    input  wire logic                            s_axis_tuser,  // [0] action
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] out_byte
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser   // [0] label_overflow
);
    import dqne_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.query_id     <= RST_QUERY_ID;
            r_cfg.header_flags <= RST_HEADER_FLAGS;
            r_cfg.query_type   <= RST_QUERY_TYPE;
            r_cfg.query_class  <= RST_QUERY_CLASS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUERY_ID:     r_cfg.query_id     <= i_cfg_data;
                CFG_HEADER_FLAGS: r_cfg.header_flags <= i_cfg_data;
                CFG_QUERY_TYPE:   r_cfg.query_type   <= i_cfg_data;
                CFG_QUERY_CLASS:  r_cfg.query_class  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    dqne_seq #(
        .LABEL_MAX (LABEL_MAX)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_char     (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_byte   (m_axis_tdata),
        .o_m_last   (m_axis_tlast),
        .o_m_ovf    (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== sv/dqne_chk.sv =====
`default_nettype none
module dqne_chk #(
    parameter int LABEL_MAX = 32
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [7:0]                      m_axis_tdata,
    input wire logic                            m_axis_tlast,
    input wire logic                            m_axis_tuser
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
        && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output word changed under stall");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item in work");

    a_last_not_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
        else $error("overflow flag on final byte");

    // overflow only when label filled
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'(LABEL_MAX))
        else $error("overflow length byte not at label limit");

endmodule

bind dns_query_name_encoder_unit dqne_chk #(.LABEL_MAX(LABEL_MAX)) u_dqne_chk (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
    import dqne_pkg::*;

    localparam int LABEL_MAX  = 32;
    localparam int CLK_HALF   = 10;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYC = 24;
    localparam int LONG_HOLD  = 400;
    localparam int MAX_PRINTS = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_QUERY_CLASS + 3'd1;

    typedef enum logic {
        ACT_CHAR = 1'b0,
        ACT_END  = 1'b1
    } t_action;

    typedef struct packed {
        t_action action;
        t_byte   ch;
    } t_name_word;

    typedef struct packed {
        t_byte data;
        logic  last;
        logic  ovf;
    } t_pkt_byte;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [15:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    // encoder model state
    t_cfg  enc_cfg = '{RST_QUERY_ID, RST_HEADER_FLAGS, RST_QUERY_TYPE, RST_QUERY_CLASS};
    t_byte lbl_buf[LABEL_MAX];
    int    lbl_len  = 0;
    bit    lbl_lost = 1'b0;
    bit    hdr_sent = 1'b0;

    t_pkt_byte  pkt_q[$];
    t_name_word name_q[$];

    bit in_fire   = 1'b0;
    bit out_fire  = 1'b0;
    bit no_idle   = 1'b0;
    int tx_gap    = 0;
    int rx_hold   = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int quiet_cyc = 0;

    int n_err         = 0;
    int n_words_queued = 0;
    int n_words_in    = 0;
    int n_bytes       = 0;
    int n_pkts        = 0;
    int n_ovf         = 0;
    int n_cfg         = 0;

    dns_query_name_encoder_unit #(
        .LABEL_MAX(LABEL_MAX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void push_pkt(t_byte b, logic last, logic ovf);
        pkt_q.push_back('{data: b, last: last, ovf: ovf});
    endfunction

    function automatic void flush_label_bytes();
        push_pkt(t_byte'(lbl_len), 1'b0, lbl_lost);
        for (int k = 0; k < lbl_len; k++) push_pkt(lbl_buf[k], 1'b0, 1'b0);
        lbl_len  = 0;
        lbl_lost = 1'b0;
    endfunction

    function automatic void encode_name_word(t_name_word w);
        if (!hdr_sent) begin
            push_pkt(enc_cfg.query_id[15:8], 1'b0, 1'b0);
            push_pkt(enc_cfg.query_id[7:0], 1'b0, 1'b0);
            push_pkt(enc_cfg.header_flags[15:8], 1'b0, 1'b0);
            push_pkt(enc_cfg.header_flags[7:0], 1'b0, 1'b0);
            push_pkt(8'd0, 1'b0, 1'b0);
            push_pkt(8'd1, 1'b0, 1'b0);
            repeat (6) push_pkt(8'd0, 1'b0, 1'b0);
            hdr_sent = 1'b1;
        end
        if (w.action == ACT_CHAR) begin
            if (w.ch == DOT_CHAR) begin
                flush_label_bytes();
            end else if (lbl_len < LABEL_MAX) begin
                lbl_buf[lbl_len] = w.ch;
                lbl_len++;
            end else begin
                lbl_lost = 1'b1;
            end
        end else begin
            flush_label_bytes();
            push_pkt(8'd0, 1'b0, 1'b0);
            push_pkt(enc_cfg.query_type[15:8], 1'b0, 1'b0);
            push_pkt(enc_cfg.query_type[7:0], 1'b0, 1'b0);
            push_pkt(enc_cfg.query_class[15:8], 1'b0, 1'b0);
            push_pkt(enc_cfg.query_class[7:0], 1'b1, 1'b0);
            hdr_sent = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (n_err < MAX_PRINTS)
            $display("%0t: packet byte %0d %s: got %h, expected %h",
                     $time, n_bytes, what, got, want);
        n_err++;
    endtask

    // monitor: config tracking, prediction, output check, watchdog
    always @(posedge i_clk) begin
        t_pkt_byte want;
        bit        cfg_fire;
        if (i_rst_n) begin
            in_fire  = s_axis_tvalid && s_axis_tready;
            out_fire = m_axis_tvalid && m_axis_tready;
            cfg_fire = i_cfg_valid && o_cfg_ready;
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_QUERY_ID:     enc_cfg.query_id     = i_cfg_data;
                    CFG_HEADER_FLAGS: enc_cfg.header_flags = i_cfg_data;
                    CFG_QUERY_TYPE:   enc_cfg.query_type   = i_cfg_data;
                    CFG_QUERY_CLASS:  enc_cfg.query_class  = i_cfg_data;
                    default: ;
                endcase
                n_cfg++;
            end
            if (in_fire) begin
                encode_name_word('{action: t_action'(s_axis_tuser), ch: s_axis_tdata});
                n_words_in++;
            end
            if (out_fire) begin
                if (pkt_q.size() == 0) begin
                    report_mismatch("arrived with nothing expected", m_axis_tdata, 8'h00);
                end else begin
                    want = pkt_q.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch("data", m_axis_tdata, want.data);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", {7'd0, m_axis_tlast}, {7'd0, want.last});
                    if (m_axis_tuser !== want.ovf)
                        report_mismatch("overflow flag", {7'd0, m_axis_tuser}, {7'd0, want.ovf});
                    if (want.last) n_pkts++;
                    if (want.ovf) n_ovf++;
                end
                n_bytes++;
            end
            if (in_fire || out_fire || cfg_fire) quiet_cyc = 0;
            else quiet_cyc++;
            if (quiet_cyc >= IDLE_LIMIT) begin
                $display("no word moved for %0d cycles, %0d bytes still due",
                         IDLE_LIMIT, pkt_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // name word driver
    always @(negedge i_clk) begin
        t_name_word w;
        if (!s_axis_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (name_q.size() != 0) begin
                w = name_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.ch;
                s_axis_tuser  <= w.action;
                tx_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // packet byte receiver
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            rx_hold   = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    task automatic add_word(input t_action a, input t_byte c);
        name_q.push_back('{action: a, ch: c});
        n_words_queued++;
    endtask

    task automatic queue_name(input bit long_first);
        int    n_lbl;
        int    len;
        int    r;
        t_byte c;
        if (!long_first && $urandom_range(0, 99) < 15) begin
            // noise: random mix of characters, dots and ends
            repeat ($urandom_range(1, 12)) begin
                c = ($urandom_range(0, 3) == 0) ? DOT_CHAR : t_byte'($urandom_range(0, 255));
                add_word(($urandom_range(0, 4) == 0) ? ACT_END : ACT_CHAR, c);
            end
            return;
        end
        n_lbl = $urandom_range(1, 4);
        for (int i = 0; i < n_lbl; i++) begin
            if (i > 0) add_word(ACT_CHAR, DOT_CHAR);
            r = $urandom_range(0, 99);
            if (long_first && i == 0) len = LABEL_MAX + 3;
            else if (r < 8) len = 0;
            else if (r < 16) len = $urandom_range(LABEL_MAX - 2, LABEL_MAX + 6);
            else len = $urandom_range(1, 10);
            repeat (len) begin
                do c = t_byte'($urandom_range(0, 255)); while (c == DOT_CHAR);
                add_word(ACT_CHAR, c);
            end
        end
        if ($urandom_range(0, 9) == 0) add_word(ACT_CHAR, DOT_CHAR);
        add_word(ACT_END, t_byte'($urandom_range(0, 255)));
    endtask

    task automatic queue_random_names(input int words);
        int stop_at;
        stop_at = n_words_queued + words;
        queue_name(1'b1);
        while (n_words_queued < stop_at) queue_name(1'b0);
        add_word(ACT_END, t_byte'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (n_words_in != n_words_queued || pkt_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] id, input logic [15:0] flags,
                                  input logic [15:0] qtype, input logic [15:0] qclass);
        write_reg(CFG_QUERY_ID, id);
        write_reg(CFG_HEADER_FLAGS, flags);
        write_reg(CFG_QUERY_TYPE, qtype);
        write_reg(CFG_QUERY_CLASS, qclass);
    endtask

    initial begin
        int base;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values
        add_word(ACT_END, 8'hFF);                   // empty name
        add_word(ACT_CHAR, DOT_CHAR);               // lone dot
        add_word(ACT_END, 8'h00);
        add_word(ACT_CHAR, DOT_CHAR);               // leading and double dots
        add_word(ACT_CHAR, DOT_CHAR);
        add_word(ACT_CHAR, 8'h61);
        add_word(ACT_CHAR, DOT_CHAR);               // trailing dot
        add_word(ACT_END, 8'h55);
        add_word(ACT_CHAR, 8'h00);                  // extreme characters
        add_word(ACT_CHAR, 8'hFF);
        add_word(ACT_CHAR, 8'h7F);
        add_word(ACT_CHAR, 8'h80);
        add_word(ACT_CHAR, DOT_CHAR - 8'd1);
        add_word(ACT_CHAR, DOT_CHAR + 8'd1);
        add_word(ACT_END, DOT_CHAR);                // end carrying a dot code
        wait_drained();

        write_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        write_reg(CFG_IDX_SPARE + 3'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        queue_random_names(100);
        wait_drained();

        // long receiver hold-off while names keep coming
        write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        base = n_words_in;
        queue_random_names(100);
        while (n_words_in < base + 30) @(negedge i_clk);
        @(posedge i_clk);
        hold_reqs++;
        wait_drained();

        // back to back, no idling on either side
        write_all_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        write_reg(CFG_IDX_SPARE + 3'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        no_idle = 1'b1;
        queue_random_names(100);
        wait_drained();
        no_idle = 1'b0;

        write_all_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        queue_random_names(60);
        wait_drained();

        $display("%0d name words sent, %0d query packets (%0d bytes) checked",
                 n_words_in, n_pkts, n_bytes);
        $display("%0d truncated labels seen, %0d register writes, %0d mismatches",
                 n_ovf, n_cfg, n_err);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/dqne_pkg.sv
sv/dqne_lbuf.sv
sv/dqne_seq.sv
sv/dns_query_name_encoder_unit.sv
sv/dqne_chk.sv
tb/tb.sv
